// ----- src/pcg32_bounded_generator_top_macros.svh -----
// Assertion macros for the PCG32 bounded generator.
// Every property is sampled on the rising clock edge and is off during reset.
`ifndef PCG32_BOUNDED_GENERATOR_TOP_MACROS_SVH
`define PCG32_BOUNDED_GENERATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define PCG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PCG_ASSERT_SAME(label, ante, cons, msg)
`define PCG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- src/pcg_pkg.sv -----
package pcg_pkg;

   localparam logic [63:0] PCG_MULT        = 64'h5851_f42d_4c95_7f2d;
   localparam logic [63:0] RESET_SEED_STATE = 64'h853c_49e6_748f_ea9b;
   localparam logic [63:0] RESET_SEED_SEQ   = 64'hda3e_39cb_94b9_5bdb;
   localparam logic [5:0]  DIV_STEPS        = 6'd32;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_RAW     = 2'd0;
   localparam mode_type MODE_BOUNDED = 2'd1;
   localparam mode_type MODE_RESEED  = 2'd2;

   // Operand pairs for the shared 32 x 32 multiplier.
   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_LL = 2'd0;
   localparam mul_sel_type MUL_HL = 2'd1;
   localparam mul_sel_type MUL_LH = 2'd2;

   typedef logic [1:0] acc_op_type;
   localparam acc_op_type ACC_HOLD  = 2'd0;
   localparam acc_op_type ACC_LOAD  = 2'd1;
   localparam acc_op_type ACC_ADDHI = 2'd2;

   typedef logic div_sel_type;
   localparam div_sel_type DIV_NEG_BOUND = 1'b0;
   localparam div_sel_type DIV_DRAW      = 1'b1;

   typedef logic [1:0] res_sel_type;
   localparam res_sel_type RES_ZERO    = 2'd0;
   localparam res_sel_type RES_LOW     = 2'd1;
   localparam res_sel_type RES_DRAW    = 2'd2;
   localparam res_sel_type RES_BOUNDED = 2'd3;

   typedef struct packed {
      logic        capture;
      logic        seed_init;
      logic        seed_add;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        state_adv;
      logic        draw_load;
      logic        div_start;
      div_sel_type div_sel;
      logic        limit_load;
      logic        res_load;
      res_sel_type res_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic bound_zero;
      logic ge_limit;
      logic div_done;
   } dp_status_type;

   // XSH-RR output permutation of a 64-bit LCG state.
   function automatic logic [31:0] xsh_rr(input logic [63:0] s);
      logic [63:0] x;
      logic [31:0] mixed;
      logic [4:0]  rot;
      logic [63:0] both;
      x     = (s >> 18) ^ s;
      mixed = x[58:27];
      rot   = s[63:59];
      both  = {mixed, mixed} >> rot;
      return both[31:0];
   endfunction

endpackage

// ----- src/pcg_dp.sv -----
module pcg_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            req_low_limit,
   input  logic [31:0]            req_high_limit,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [63:0]            csr_data,
   input  pcg_pkg::dp_cmd_type    cmd,
   output pcg_pkg::dp_status_type status,
   output logic [31:0]            rsp_value
);

   logic [63:0] seed_state_ff, seed_state_in;
   logic [63:0] seed_seq_ff, seed_seq_in;
   logic [63:0] lcg_ff, lcg_in;
   logic [63:0] inc_ff, inc_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] bound_ff, bound_in;
   logic [31:0] draw_ff, draw_in;
   logic [31:0] limit_ff, limit_in;
   logic [63:0] prod_ff;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] res_ff, res_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_prod;
   logic [32:0] trial, diff;
   logic [31:0] rem_step;

   always_comb begin
      case (cmd.mul_sel)
         pcg_pkg::MUL_HL: begin
            mul_a = lcg_ff[63:32];
            mul_b = pcg_pkg::PCG_MULT[31:0];
         end
         pcg_pkg::MUL_LH: begin
            mul_a = lcg_ff[31:0];
            mul_b = pcg_pkg::PCG_MULT[63:32];
         end
         default: begin
            mul_a = lcg_ff[31:0];
            mul_b = pcg_pkg::PCG_MULT[31:0];
         end
      endcase
   end

   assign mul_prod = 64'(mul_a) * 64'(mul_b);

   // One restoring step of the remainder computation.
   assign trial    = {rem_ff, dvd_ff[31]};
   assign diff     = trial - {1'b0, bound_ff};
   assign rem_step = diff[32] ? trial[31:0] : diff[31:0];

   always_comb begin
      seed_state_in = seed_state_ff;
      seed_seq_in   = seed_seq_ff;
      if (csr_write) begin
         if (csr_index) begin
            seed_seq_in = csr_data;
         end else begin
            seed_state_in = csr_data;
         end
      end

      lcg_in = lcg_ff;
      inc_in = inc_ff;
      if (cmd.seed_init) begin
         inc_in = {seed_seq_ff[62:0], 1'b1};
         lcg_in = '0;
      end else if (cmd.seed_add) begin
         lcg_in = lcg_ff + seed_state_ff;
      end else if (cmd.state_adv) begin
         lcg_in = acc_ff + inc_ff;
      end

      case (cmd.acc_op)
         pcg_pkg::ACC_LOAD:  acc_in = prod_ff;
         pcg_pkg::ACC_ADDHI: acc_in = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
         default:            acc_in = acc_ff;
      endcase

      low_in   = cmd.capture ? req_low_limit : low_ff;
      bound_in = cmd.capture ? (req_high_limit - req_low_limit) : bound_ff;
      draw_in  = cmd.draw_load ? pcg_pkg::xsh_rr(lcg_ff) : draw_ff;
      limit_in = cmd.limit_load ? rem_ff : limit_ff;

      rem_in = rem_ff;
      dvd_in = dvd_ff;
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         dvd_in = (cmd.div_sel == pcg_pkg::DIV_DRAW) ? draw_ff : (32'd0 - bound_ff);
         cnt_in = pcg_pkg::DIV_STEPS;
      end else if (cnt_ff != '0) begin
         rem_in = rem_step;
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
      end

      res_in = res_ff;
      if (cmd.res_load) begin
         case (cmd.res_sel)
            pcg_pkg::RES_LOW:     res_in = low_ff;
            pcg_pkg::RES_DRAW:    res_in = draw_ff;
            pcg_pkg::RES_BOUNDED: res_in = low_ff + rem_ff;
            default:              res_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_state_ff <= pcg_pkg::RESET_SEED_STATE;
         seed_seq_ff   <= pcg_pkg::RESET_SEED_SEQ;
         cnt_ff        <= '0;
      end else begin
         seed_state_ff <= seed_state_in;
         seed_seq_ff   <= seed_seq_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      lcg_ff   <= lcg_in;
      inc_ff   <= inc_in;
      low_ff   <= low_in;
      bound_ff <= bound_in;
      draw_ff  <= draw_in;
      limit_ff <= limit_in;
      prod_ff  <= mul_prod;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      res_ff   <= res_in;
   end

   assign status.bound_zero = (bound_ff == '0);
   assign status.ge_limit   = (draw_ff >= limit_ff);
   assign status.div_done   = (cnt_ff == '0);
   assign rsp_value         = res_ff;

endmodule

// ----- src/pcg_ctrl.sv -----
module pcg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pcg_pkg::mode_type      req_mode,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   csr_ready,
   input  pcg_pkg::dp_status_type status,
   output pcg_pkg::dp_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_SEED_ZERO = 4'd1;
   localparam logic [3:0] ST_SEED_ADV1 = 4'd2;
   localparam logic [3:0] ST_SEED_ADD  = 4'd3;
   localparam logic [3:0] ST_SEED_ADV2 = 4'd4;
   localparam logic [3:0] ST_RAW_ADV   = 4'd5;
   localparam logic [3:0] ST_BND_START = 4'd6;
   localparam logic [3:0] ST_LIM_DIV   = 4'd7;
   localparam logic [3:0] ST_BND_ADV   = 4'd8;
   localparam logic [3:0] ST_BND_CHK   = 4'd9;
   localparam logic [3:0] ST_BND_DIV   = 4'd10;
   localparam logic [3:0] ST_RESULT    = 4'd11;

   localparam logic [2:0] PH_LAST = 3'd4;

   logic [3:0]           state_ff, state_in;
   logic [2:0]           ph_ff, ph_in;
   logic                 init_ff, init_in;
   logic                 valid_ff, valid_in;
   pcg_pkg::res_sel_type res_sel_ff, res_sel_in;
   logic                 adv_active;
   logic                 adv_end;
   logic                 out_free;

   assign adv_active = state_ff inside {ST_SEED_ADV1, ST_SEED_ADV2, ST_RAW_ADV, ST_BND_ADV};
   assign adv_end    = adv_active && (ph_ff == PH_LAST);
   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = !init_ff;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      init_in    = init_ff;
      res_sel_in = res_sel_ff;
      ph_in      = (adv_active && !adv_end) ? ph_ff + 3'd1 : 3'd0;

      // State advance: three partial products, then add the increment.
      if (adv_active) begin
         case (ph_ff)
            3'd0: begin
               cmd.mul_sel   = pcg_pkg::MUL_LL;
               cmd.draw_load = 1'b1;
            end
            3'd1: begin
               cmd.mul_sel = pcg_pkg::MUL_HL;
               cmd.acc_op  = pcg_pkg::ACC_LOAD;
            end
            3'd2: begin
               cmd.mul_sel = pcg_pkg::MUL_LH;
               cmd.acc_op  = pcg_pkg::ACC_ADDHI;
            end
            3'd3: begin
               cmd.acc_op = pcg_pkg::ACC_ADDHI;
            end
            default: begin
               cmd.state_adv = 1'b1;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               case (req_mode)
                  pcg_pkg::MODE_RAW:     state_in = ST_RAW_ADV;
                  pcg_pkg::MODE_BOUNDED: state_in = ST_BND_START;
                  pcg_pkg::MODE_RESEED:  state_in = ST_SEED_ZERO;
                  default: begin
                     res_sel_in = pcg_pkg::RES_ZERO;
                     state_in   = ST_RESULT;
                  end
               endcase
            end
         end
         ST_SEED_ZERO: begin
            cmd.seed_init = 1'b1;
            state_in      = ST_SEED_ADV1;
         end
         ST_SEED_ADV1: begin
            if (adv_end) begin
               state_in = ST_SEED_ADD;
            end
         end
         ST_SEED_ADD: begin
            cmd.seed_add = 1'b1;
            state_in     = ST_SEED_ADV2;
         end
         ST_SEED_ADV2: begin
            if (adv_end) begin
               if (init_ff) begin
                  init_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  res_sel_in = pcg_pkg::RES_ZERO;
                  state_in   = ST_RESULT;
               end
            end
         end
         ST_RAW_ADV: begin
            if (adv_end) begin
               res_sel_in = pcg_pkg::RES_DRAW;
               state_in   = ST_RESULT;
            end
         end
         ST_BND_START: begin
            if (status.bound_zero) begin
               res_sel_in = pcg_pkg::RES_LOW;
               state_in   = ST_RESULT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = pcg_pkg::DIV_NEG_BOUND;
               state_in      = ST_LIM_DIV;
            end
         end
         ST_LIM_DIV: begin
            if (status.div_done) begin
               cmd.limit_load = 1'b1;
               state_in       = ST_BND_ADV;
            end
         end
         ST_BND_ADV: begin
            if (adv_end) begin
               state_in = ST_BND_CHK;
            end
         end
         ST_BND_CHK: begin
            // A draw below the rejection threshold is thrown away.
            if (status.ge_limit) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = pcg_pkg::DIV_DRAW;
               state_in      = ST_BND_DIV;
            end else begin
               state_in = ST_BND_ADV;
            end
         end
         ST_BND_DIV: begin
            if (status.div_done) begin
               res_sel_in = pcg_pkg::RES_BOUNDED;
               state_in   = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = res_sel_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      valid_in = cmd.res_load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SEED_ZERO;
         ph_ff      <= '0;
         init_ff    <= 1'b1;
         valid_ff   <= 1'b0;
         res_sel_ff <= pcg_pkg::RES_ZERO;
      end else begin
         state_ff   <= state_in;
         ph_ff      <= ph_in;
         init_ff    <= init_in;
         valid_ff   <= valid_in;
         res_sel_ff <= res_sel_in;
      end
   end

endmodule

// ----- src/pcg32_bounded_generator_top.sv -----
// PCG32 generator, one item at a time: a new beat is taken the cycle after a result loads.
// Bounded draw: two 32-step passes of the restoring remainder unit and the shared
// multiply-add per draw.
// Reset is synchronous, active high; after it a seeding pass runs with
// req_tready and csr_ready low.
`include "pcg32_bounded_generator_top_macros.svh"
module pcg32_bounded_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // low_limit[31:0], high_limit[63:32]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // value[31:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   pcg_pkg::dp_cmd_type    cmd;
   pcg_pkg::dp_status_type status;
   logic                   csr_write;

   assign csr_write = csr_valid && csr_ready;

   pcg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_ready  (csr_ready),
      .status     (status),
      .cmd        (cmd)
   );

   pcg_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_low_limit  (req_tdata[31:0]),
      .req_high_limit (req_tdata[63:32]),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_value      (rsp_tdata)
   );

   `PCG_ASSERT_SAME(a_no_overwrite, cmd.res_load, !rsp_tvalid || rsp_tready, "result overwritten")
   `PCG_ASSERT_NEXT(a_load_shows, cmd.res_load, rsp_tvalid, "loaded result not presented")
   `PCG_ASSERT_NEXT(a_busy_after_beat, req_tvalid && req_tready, !req_tready, "second beat taken")
   `PCG_ASSERT_NEXT(a_div_runs, cmd.div_start, !status.div_done, "remainder unit done too early")

endmodule

// ----- verif/pcg32_tb_pkg.sv -----
`timescale 1ns / 1ps
package pcg32_tb_pkg;

   typedef enum logic {
      REG_SEED_STATE    = 1'b0,
      REG_SEED_SEQUENCE = 1'b1
   } seed_reg_type;

   // The block has no name for the fourth mode; it must leave the state alone.
   localparam pcg_pkg::mode_type MODE_UNUSED = 2'd3;

endpackage

// ----- verif/pcg32_draw_checker.sv -----
`timescale 1ns / 1ps
module pcg32_draw_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,  // low_limit[31:0], high_limit[63:32]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,  // value[31:0]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data,
   input  logic        end_of_test,
   output int          outstanding,
   output int          fail_count
);

   logic [63:0] seed_state_reg;
   logic [63:0] seed_seq_reg;
   logic [63:0] gen_state;
   logic [63:0] gen_increment;
   logic [31:0] expected_values[$];
   logic [31:0] want_value;
   logic        leftover_checked;
   int          result_index;

   initial begin
      outstanding      = 0;
      fail_count       = 0;
      leftover_checked = 1'b0;
      result_index     = 0;
   end

   function automatic logic [31:0] permute_state(input logic [63:0] s);
      logic [63:0] folded;
      logic [31:0] mixed;
      logic [4:0]  rot;
      folded = (s >> 18) ^ s;
      mixed  = folded[58:27];
      rot    = s[63:59];
      return (mixed >> rot) | (mixed << (5'd0 - rot));
   endfunction

   // Output is taken from the state before the advance.
   function logic [31:0] next_raw();
      logic [31:0] out_word;
      out_word  = permute_state(gen_state);
      gen_state = gen_state * pcg_pkg::PCG_MULT + gen_increment;
      return out_word;
   endfunction

   function void reseed_stream();
      logic [31:0] unused_word;
      gen_increment = {seed_seq_reg[62:0], 1'b1};
      gen_state     = 64'd0;
      unused_word   = next_raw();
      gen_state     = gen_state + seed_state_reg;
      unused_word   = next_raw();
   endfunction

   // Rejection sampling keeps the bounded result unbiased.
   function logic [31:0] next_bounded(input logic [31:0] lo, input logic [31:0] hi);
      logic [31:0] bound;
      logic [31:0] reject_below;
      logic [31:0] draw;
      bound = hi - lo;
      if (bound == 32'd0) begin
         return lo;
      end
      reject_below = (32'd0 - bound) % bound;
      draw = next_raw();
      while (draw < reject_below) begin
         draw = next_raw();
      end
      return lo + (draw % bound);
   endfunction

   function logic [31:0] predict_value(input pcg_pkg::mode_type mode,
                                       input logic [63:0] beat);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = beat[31:0];
      hi = beat[63:32];
      case (mode)
         pcg_pkg::MODE_RAW:     return next_raw();
         pcg_pkg::MODE_BOUNDED: return next_bounded(lo, hi);
         pcg_pkg::MODE_RESEED: begin
            reseed_stream();
            return 32'd0;
         end
         default:               return 32'd0;
      endcase
   endfunction

   task report_mismatch(input string what);
      $display("ERROR %0t: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_values.delete();
         seed_state_reg = pcg_pkg::RESET_SEED_STATE;
         seed_seq_reg   = pcg_pkg::RESET_SEED_SEQ;
         reseed_stream();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0) begin
               report_mismatch($sformatf("result beat %0h arrived with nothing expected",
                                         rsp_tdata));
            end else begin
               want_value = expected_values.pop_front();
               if (rsp_tdata !== want_value) begin
                  report_mismatch($sformatf("result %0d: value %08h, expected %08h",
                                            result_index, rsp_tdata, want_value));
               end
            end
            result_index++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == pcg32_tb_pkg::REG_SEED_SEQUENCE) begin
               seed_seq_reg = csr_data;
            end else begin
               seed_state_reg = csr_data;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_values.push_back(predict_value(req_tuser, req_tdata));
         end
         if (end_of_test && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_values.size() != 0) begin
               report_mismatch($sformatf("%0d expected results never arrived",
                                         expected_values.size()));
            end
         end
      end
      outstanding = expected_values.size();
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [63:0]       req_tdata   = '0;
   pcg_pkg::mode_type req_tuser   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [31:0]       rsp_tdata;
   logic              csr_valid   = 1'b0;
   logic              csr_ready;
   logic              csr_index   = 1'b0;
   logic [63:0]       csr_data    = '0;
   logic              end_of_test = 1'b0;
   int                outstanding;
   int                fail_count;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mode_counts[4];
   int reg_writes = 0;

   always #4 clock = ~clock;

   pcg32_bounded_generator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pcg32_draw_checker draw_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .end_of_test (end_of_test),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Valid stays high between back-to-back beats and drops only for a gap.
   task send_item(input pcg_pkg::mode_type mode, input logic [31:0] lo,
                  input logic [31:0] hi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {hi, lo};
      req_tuser  = mode;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
      mode_counts[mode]++;
   endtask

   task wait_idle();
      req_tvalid = 1'b0;
      while (outstanding != 0) begin
         @(negedge clock);
      end
   endtask

   task write_seed(input pcg32_tb_pkg::seed_reg_type which, input logic [63:0] value);
      csr_index = which;
      csr_data  = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid = 1'b0;
      reg_writes++;
   endtask

   task send_random_item();
      int          pick;
      logic [31:0] lo;
      logic [31:0] hi;
      pick = $urandom_range(99);
      lo   = $urandom;
      hi   = $urandom;
      if (pick < 30) begin
         send_item(pcg_pkg::MODE_RAW, lo, hi);
      end else if (pick < 75) begin
         case ($urandom_range(4))
            0: hi = lo + $urandom_range(16, 1);
            1: ;
            2: hi = lo;
            3: hi = lo + 32'h8000_0000 + $urandom_range(255);
            default: hi = lo + (32'd1 << $urandom_range(31));
         endcase
         send_item(pcg_pkg::MODE_BOUNDED, lo, hi);
      end else if (pick < 90) begin
         send_item(pcg_pkg::MODE_RESEED, lo, hi);
      end else begin
         send_item(pcg32_tb_pkg::MODE_UNUSED, lo, hi);
      end
   endtask

   initial begin
      logic [63:0] phase_state[5];
      logic [63:0] phase_seq[5];
      int          phase_send[5];
      int          phase_stall[5];

      phase_state = '{64'd0, '1, {$urandom, $urandom}, {$urandom, $urandom},
                      pcg_pkg::RESET_SEED_STATE};
      phase_seq   = '{'1, 64'd0, {$urandom, $urandom}, {$urandom, $urandom},
                      pcg_pkg::RESET_SEED_SEQ};
      phase_send  = '{0, 58, 0, 8, 0};
      phase_stall = '{0, 0, 58, 8, 0};

      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed part runs first on the seeds left by reset.
      send_item(pcg_pkg::MODE_RAW, 32'd0, 32'd0);
      send_item(pcg32_tb_pkg::MODE_UNUSED, '1, '1);
      send_item(pcg_pkg::MODE_RESEED, 32'd0, 32'd0);
      send_item(pcg_pkg::MODE_RAW, '1, '1);
      send_item(pcg_pkg::MODE_BOUNDED, 32'd0, 32'd0);
      send_item(pcg_pkg::MODE_BOUNDED, '1, '1);
      send_item(pcg_pkg::MODE_BOUNDED, 32'd0, 32'd1);
      send_item(pcg_pkg::MODE_BOUNDED, 32'd0, '1);
      send_item(pcg_pkg::MODE_BOUNDED, '1, 32'd0);
      send_item(pcg_pkg::MODE_BOUNDED, 32'd1, 32'd0);
      send_item(pcg_pkg::MODE_BOUNDED, 32'd0, 32'h8000_0001);
      send_item(pcg_pkg::MODE_BOUNDED, 32'h8000_0000, 32'h7fff_ffff);
      send_item(pcg_pkg::MODE_BOUNDED, 32'd5, 32'd7);
      send_item(pcg_pkg::MODE_BOUNDED, 32'd100, 32'd103);
      wait_idle();
      write_seed(pcg32_tb_pkg::REG_SEED_STATE, 64'd0);
      write_seed(pcg32_tb_pkg::REG_SEED_SEQUENCE, 64'd0);
      send_item(pcg_pkg::MODE_RESEED, 32'd0, 32'd0);
      send_item(pcg_pkg::MODE_RAW, 32'd0, 32'd0);
      send_item(pcg_pkg::MODE_BOUNDED, 32'd0, 32'd10);
      wait_idle();
      write_seed(pcg32_tb_pkg::REG_SEED_STATE, '1);
      write_seed(pcg32_tb_pkg::REG_SEED_SEQUENCE, '1);
      send_item(pcg_pkg::MODE_RESEED, '1, '1);
      send_item(pcg_pkg::MODE_RAW, 32'd0, 32'd0);
      send_item(pcg_pkg::MODE_BOUNDED, 32'hffff_fff0, '1);
      send_item(pcg32_tb_pkg::MODE_UNUSED, 32'haaaa_aaaa, 32'h5555_5555);
      send_item(pcg_pkg::MODE_RAW, 32'h5555_5555, 32'haaaa_aaaa);

      for (int p = 0; p < 5; p++) begin
         wait_idle();
         write_seed(pcg32_tb_pkg::REG_SEED_STATE, phase_state[p]);
         write_seed(pcg32_tb_pkg::REG_SEED_SEQUENCE, phase_seq[p]);
         send_idle_pct = phase_send[p];
         rsp_stall_pct = phase_stall[p];
         send_item(pcg_pkg::MODE_RESEED, $urandom, $urandom);
         repeat (249) send_random_item();
      end

      wait_idle();
      repeat (50) @(negedge clock);
      end_of_test = 1'b1;
      repeat (2) @(negedge clock);

      $display("Covered %0d raw, %0d bounded, %0d reseed and %0d unused-mode beats,",
               mode_counts[pcg_pkg::MODE_RAW], mode_counts[pcg_pkg::MODE_BOUNDED],
               mode_counts[pcg_pkg::MODE_RESEED], mode_counts[pcg32_tb_pkg::MODE_UNUSED]);
      $display("with %0d seed register writes over five idle and stall profiles.",
               reg_writes);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results still outstanding.", outstanding);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
